// ----- rtl/olist_pkg.sv -----
// shared types and constants for the ordered list engine
package olist_pkg;

    localparam int KEY_BITS      = 16;
    localparam int IDX_BITS      = 4;
    localparam int CNT_BITS      = 5;
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 16;

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_FIND   = 3'd2,
        KIND_READ   = 3'd3,
        KIND_SWAP   = 3'd4,
        KIND_UP     = 3'd5,
        KIND_DOWN   = 3'd6,
        KIND_NONE   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_APPEND = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_SWAP   = 3'd3,
        CELL_UP     = 3'd4,
        CELL_DOWN   = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [KEY_BITS-1:0]   key;
        logic [IDX_BITS-1:0]   ia;
        logic [IDX_BITS-1:0]   ib;
        logic [IDX_BITS-1:0]   lo;
        logic [CNT_BITS-1:0]   hi;
    } cmd_t;

    typedef struct packed {
        logic                  hit_seen;
        logic [IDX_BITS-1:0]   hit_idx;
        logic [KEY_BITS-1:0]   val_a;
        logic [KEY_BITS-1:0]   val_b;
    } link_t;

endpackage

// ----- rtl/ordered_list_engine.sv -----
// Ordered list of up to DEPTH keys held in a row of cells, one entry per cell.
// Each item asks for one operation (append, remove, find, read, swap, move up,
// move down) and gives one result item with a status and the count afterwards.
// An item is taken every cycle while the result register is free or being
// drained; its result is registered and appears in the cycle after acceptance.
// All cells compare the key at once and shift with their neighbors in the same
// edge; the first-match and read buses ripple through the row of cells, so the
// clock period grows with DEPTH.
module ordered_list_engine #(
    parameter int DEPTH     = olist_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = olist_pkg::KEY_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,    // kind
    input  logic [23:0] s_tdata,    // key[15:0], index_a[19:16], index_b[23:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,    // status
    output logic [31:0] m_tdata     // found_index[3:0], value[19:4], count[24:20]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (KEY_WIDTH < olist_pkg::KEY_BITS) ? KEY_WIDTH : olist_pkg::KEY_BITS;

    olist_pkg::cmd_t  cmd;
    logic [CW-1:0]    cnt;
    olist_pkg::link_t link [0:DEPTH];
    logic [SW-1:0]    entry [0:DEPTH-1];

    assign link[0] = '0;

    olist_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .cnt      (cnt),
        .link_end (link[DEPTH])
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        olist_cell #(
            .IDX (i),
            .CW  (CW),
            .SW  (SW)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cnt         (cnt),
            .link_in     (link[i]),
            .link_out    (link[i+1]),
            .bus_a       (link[DEPTH].val_a),
            .bus_b       (link[DEPTH].val_b),
            .left_entry  (entry[(i == 0) ? 0 : i - 1]),
            .right_entry (entry[(i == DEPTH - 1) ? i : i + 1]),
            .entry       (entry[i])
        );
    end

endmodule

// ----- rtl/olist_cell.sv -----
// one list slot: holds an entry, compares it and shifts with its neighbors
module olist_cell #(
    parameter int IDX   = 0,
    parameter int CW    = 5,
    parameter int SW    = 16
) (
    input  logic                aclk,
    input  olist_pkg::cmd_t     cmd,
    input  logic [CW-1:0]       cnt,
    input  olist_pkg::link_t    link_in,
    output olist_pkg::link_t    link_out,
    input  logic [olist_pkg::KEY_BITS-1:0] bus_a,
    input  logic [olist_pkg::KEY_BITS-1:0] bus_b,
    input  logic [SW-1:0]       left_entry,
    input  logic [SW-1:0]       right_entry,
    output logic [SW-1:0]       entry
);

    logic [SW-1:0] entry_reg;
    logic [SW-1:0] entry_next;
    logic          valid;
    logic          hit;
    logic          first;

    assign entry = entry_reg;
    assign valid = IDX < int'(cnt);
    assign hit   = valid && (entry_reg == SW'(cmd.key));
    assign first = hit && !link_in.hit_seen;

    always_comb begin
        link_out.hit_seen = link_in.hit_seen | hit;
        link_out.hit_idx  = link_in.hit_idx
                          | (first ? olist_pkg::IDX_BITS'(IDX) : '0);
        link_out.val_a    = link_in.val_a
                          | ((int'(cmd.ia) == IDX) ? olist_pkg::KEY_BITS'(entry_reg) : '0);
        link_out.val_b    = link_in.val_b
                          | ((int'(cmd.ib) == IDX) ? olist_pkg::KEY_BITS'(entry_reg) : '0);
    end

    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            olist_pkg::CELL_HOLD: begin
                entry_next = entry_reg;
            end
            olist_pkg::CELL_APPEND: begin
                if (IDX == int'(cnt)) entry_next = SW'(cmd.key);
            end
            olist_pkg::CELL_REMOVE: begin
                if (link_out.hit_seen) entry_next = right_entry;
            end
            olist_pkg::CELL_SWAP: begin
                if (IDX == int'(cmd.ia)) entry_next = SW'(bus_b);
                else if (IDX == int'(cmd.ib)) entry_next = SW'(bus_a);
            end
            olist_pkg::CELL_UP: begin
                if (IDX == int'(cmd.lo)) entry_next = SW'(bus_a);
                else if (IDX > int'(cmd.lo) && IDX <= int'(cmd.ia)) entry_next = left_entry;
            end
            olist_pkg::CELL_DOWN: begin
                if (IDX == int'(cmd.hi)) entry_next = SW'(bus_a);
                else if (IDX >= int'(cmd.ia) && IDX < int'(cmd.hi)) entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/olist_ctrl.sv -----
// decode, range checks, fill count and registered result of the list engine
module olist_ctrl #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          s_tuser,    // kind
    input  logic [23:0]         s_tdata,    // key, index_a, index_b
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          m_tuser,    // status
    output logic [31:0]         m_tdata,    // found_index, value, count, zero fill
    output olist_pkg::cmd_t     cmd,
    output logic [CW-1:0]       cnt,
    input  olist_pkg::link_t    link_end
);

    localparam int CMPW = (CW > olist_pkg::CNT_BITS) ? CW : olist_pkg::CNT_BITS;

    logic [CW-1:0]                     cnt_reg;
    logic [CW-1:0]                     cnt_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    olist_pkg::status_t                out_status_reg;
    olist_pkg::status_t                out_status_next;
    logic [olist_pkg::IDX_BITS-1:0]    out_fidx_reg;
    logic [olist_pkg::IDX_BITS-1:0]    out_fidx_next;
    logic [olist_pkg::KEY_BITS-1:0]    out_value_reg;
    logic [olist_pkg::KEY_BITS-1:0]    out_value_next;
    logic [olist_pkg::CNT_BITS-1:0]    out_count_reg;
    logic [olist_pkg::CNT_BITS-1:0]    out_count_next;

    olist_pkg::kind_t                  kind;
    logic [olist_pkg::KEY_BITS-1:0]    key;
    logic [olist_pkg::IDX_BITS-1:0]    ia;
    logic [olist_pkg::IDX_BITS-1:0]    ib;
    logic [olist_pkg::CNT_BITS-1:0]    hi_sum;
    logic                              accept;
    logic                              ia_ok;
    logic                              ib_ok;
    logic                              down_ok;
    logic                              full;

    assign kind   = olist_pkg::kind_t'(s_tuser);
    assign key    = s_tdata[15:0];
    assign ia     = s_tdata[19:16];
    assign ib     = s_tdata[23:20];
    assign hi_sum = olist_pkg::CNT_BITS'(ia) + olist_pkg::CNT_BITS'(ib);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ia_ok   = CMPW'(ia) < CMPW'(cnt_reg);
    assign ib_ok   = CMPW'(ib) < CMPW'(cnt_reg);
    assign down_ok = CMPW'(hi_sum) < CMPW'(cnt_reg);
    assign full    = cnt_reg == CW'(DEPTH);

    assign cnt = cnt_reg;

    always_comb begin
        cmd.op  = olist_pkg::CELL_HOLD;
        cmd.key = key;
        cmd.ia  = ia;
        cmd.ib  = ib;
        cmd.lo  = ia - ib;
        cmd.hi  = hi_sum;

        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = olist_pkg::ST_OK;
        out_fidx_next   = '0;
        out_value_next  = '0;

        unique case (kind)
            olist_pkg::KIND_APPEND: begin
                if (full) begin
                    out_status_next = olist_pkg::ST_FULL;
                end else begin
                    cmd.op   = olist_pkg::CELL_APPEND;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            olist_pkg::KIND_REMOVE: begin
                cmd.op = olist_pkg::CELL_REMOVE;
                if (link_end.hit_seen) cnt_next = cnt_reg - CW'(1);
                else out_status_next = olist_pkg::ST_NOT_FOUND;
            end
            olist_pkg::KIND_FIND: begin
                if (link_end.hit_seen) out_fidx_next = link_end.hit_idx;
                else out_status_next = olist_pkg::ST_NOT_FOUND;
            end
            olist_pkg::KIND_READ: begin
                if (ia_ok) out_value_next = link_end.val_a;
                else out_status_next = olist_pkg::ST_RANGE;
            end
            olist_pkg::KIND_SWAP: begin
                if (ia_ok && ib_ok) cmd.op = olist_pkg::CELL_SWAP;
                else out_status_next = olist_pkg::ST_RANGE;
            end
            olist_pkg::KIND_UP: begin
                if (ia_ok && ib <= ia) cmd.op = olist_pkg::CELL_UP;
                else out_status_next = olist_pkg::ST_RANGE;
            end
            olist_pkg::KIND_DOWN: begin
                if (down_ok) cmd.op = olist_pkg::CELL_DOWN;
                else out_status_next = olist_pkg::ST_RANGE;
            end
            default: begin
                out_status_next = olist_pkg::ST_OK;
            end
        endcase

        out_count_next = olist_pkg::CNT_BITS'(cnt_next);

        if (!accept) begin
            cmd.op   = olist_pkg::CELL_HOLD;
            cnt_next = cnt_reg;
        end else begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= out_status_next;
            out_fidx_reg   <= out_fidx_next;
            out_value_reg  <= out_value_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_count_reg, out_value_reg, out_fidx_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) <= DEPTH)
        else $error("fill count above depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && kind == olist_pkg::KIND_APPEND && !full
        |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("append did not grow the list");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted item gave no result");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != olist_pkg::ST_OK
        |-> out_fidx_reg == '0 && out_value_reg == '0)
        else $error("failed operation carries data");

endmodule
